// File: sv/plb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional list buffer.
// No dependencies.
package plb_pkg;

    // request codes
    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_BACK  = 3'd1;
    localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
    localparam logic [2:0] ACT_DEL_BACK  = 3'd3;
    localparam logic [2:0] ACT_INS_AT    = 3'd4;
    localparam logic [2:0] ACT_DEL_AT    = 3'd5;
    localparam logic [2:0] ACT_LIST      = 3'd6;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_LISTED  = 2'd3;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

endpackage

// File: sv/plb_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds a single byte slot.
// Depends on plb_pkg.
module plb_cell
    import plb_pkg::*;
#(
    parameter int IW    = 4,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IW-1:0]     key,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic [DATA_W-1:0] head_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                // open a gap at key, shift the tail one place back
                if (MY_IDX > key)
                    data_next = left_data;
                else if (MY_IDX == key)
                    data_next = ctrl.value;
            end
            CELL_DELETE:
            begin
                // close the gap at key
                if (MY_IDX >= key)
                    data_next = right_data;
            end
            CELL_ROTATE:
            begin
                // rotate the occupied run; head wraps to key (last used slot)
                if (MY_IDX < key)
                    data_next = right_data;
                else if (MY_IDX == key)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: sv/positional_list_buffer.sv
`timescale 1ns / 1ps
// Timing: a status beat is valid the cycle after its request is accepted; a listing's
//   first beat passes the S_LIST state, then the output register. Beats and mutating
//   requests go one per cycle while the output is taken; a listing holds off requests to
//   its last beat, the chain rotating a place per beat to bring each element to the head.
// Reset (rst_n, async, active low) empties the list; slot contents are not cleared.
// Depends on plb_pkg and plb_cell.
module positional_list_buffer
    import plb_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], value[10:3], position[18:11], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], element[9:2], length[14:10], zero pad
    output logic        m_tlast    // last_of_run
);

    // index width for slots, count width that can hold CAPACITY itself
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // position compare width: wide enough for the 8-bit position and count + 1
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    // request fields
    logic [2:0]        in_action;
    logic [DATA_W-1:0] in_value;
    logic [7:0]        in_position;

    assign in_action   = s_tdata[2:0];
    assign in_value    = s_tdata[10:3];
    assign in_position = s_tdata[18:11];

    // control state
    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     remain_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_element_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic              out_last_reg;

    logic              accept;
    logic              out_free;
    logic              list_fire;
    logic              load_beat;

    // decode of the accepted request
    logic              is_insert;
    logic              is_delete;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic              pos_ok;
    logic              full;
    logic              mutate;
    logic [1:0]        req_status;
    logic [CW-1:0]     count_next;
    logic [PW-1:0]     key_wide;

    // chain control
    cell_ctrl_t        cell_ctrl;
    logic [IW-1:0]     cell_key;
    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign list_fire = (state_reg == S_LIST) && out_free;
    // a new beat enters the output register this cycle
    assign load_beat = (accept && (in_action != ACT_LIST)) || list_fire;

    assign cnt_ext = PW'(count_reg);

    always_comb
    begin
        is_insert = 1'b0;
        is_delete = 1'b0;
        pos_ext   = PW'(in_position);
        case (in_action)
            ACT_INS_FRONT:
            begin
                is_insert = 1'b1;
                pos_ext   = PW'(1);
            end
            ACT_INS_BACK:
            begin
                is_insert = 1'b1;
                pos_ext   = cnt_ext + PW'(1);
            end
            ACT_INS_AT:
            begin
                is_insert = 1'b1;
            end
            ACT_DEL_FRONT:
            begin
                is_delete = 1'b1;
                pos_ext   = PW'(1);
            end
            ACT_DEL_BACK:
            begin
                is_delete = 1'b1;
                pos_ext   = cnt_ext;
            end
            ACT_DEL_AT:
            begin
                is_delete = 1'b1;
            end
            default:
            begin
                is_insert = 1'b0;
                is_delete = 1'b0;
            end
        endcase

        // range check comes before the full check for inserts
        if (is_insert)
            pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
        else
            pos_ok = (count_reg != '0) && (pos_ext != '0) && (pos_ext <= cnt_ext);

        full     = (count_reg == CAP_C);
        key_wide = pos_ext - PW'(1);

        mutate     = 1'b0;
        req_status = ST_IGNORED;
        count_next = count_reg;
        if (is_insert && pos_ok)
        begin
            if (full)
                req_status = ST_FULL;
            else
            begin
                req_status = ST_DONE;
                mutate     = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
        else if (is_delete && pos_ok)
        begin
            req_status = ST_DONE;
            mutate     = 1'b1;
            count_next = count_reg - CW'(1);
        end
    end

    // chain command: one shift per mutation, one rotation per listed beat
    always_comb
    begin
        cell_ctrl.value = in_value;
        cell_ctrl.op    = CELL_HOLD;
        cell_key        = key_wide[IW-1:0];
        if (accept && mutate)
            cell_ctrl.op = is_insert ? CELL_INSERT : CELL_DELETE;
        else if (list_fire)
        begin
            cell_ctrl.op = CELL_ROTATE;
            cell_key     = IW'(count_reg - CW'(1));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = in_value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            plb_cell #(
                .IW    (IW),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .key        (cell_key),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // state, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            remain_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_DONE;
            out_element_reg <= '0;
            out_length_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !load_beat)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_action == ACT_LIST)
                        begin
                            // an empty list gives no beats at all
                            if (count_reg != '0)
                            begin
                                state_reg  <= S_LIST;
                                remain_reg <= count_reg;
                            end
                        end
                        else
                        begin
                            count_reg       <= count_next;
                            out_valid_reg   <= 1'b1;
                            out_status_reg  <= req_status;
                            out_element_reg <= '0;
                            out_length_reg  <= LEN_W'(count_next);
                            out_last_reg    <= 1'b1;
                        end
                    end
                end
                S_LIST:
                begin
                    if (list_fire)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= ST_LISTED;
                        out_element_reg <= cell_data[0];
                        out_length_reg  <= LEN_W'(count_reg);
                        out_last_reg    <= (remain_reg == CW'(1));
                        remain_reg      <= remain_reg - CW'(1);
                        if (remain_reg == CW'(1))
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_element_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // held count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("held count above capacity");

    // a listing walks a nonzero number of elements no larger than the count
    a_list_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> ((remain_reg != '0) && (remain_reg <= count_reg)))
        else $error("listing counter out of range");

    // a beat that is not the last of its run only occurs mid listing
    a_nonlast_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (state_reg == S_LIST))
        else $error("non-final beat outside listing");

    // the count does not move while a listing runs
    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |=> $stable(count_reg))
        else $error("count changed during listing");
`endif

endmodule

// File: dv/plb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the positional list buffer: tracks list contents from accepted requests
// and compares every result beat in order. Depends on plb_pkg.
module plb_checker
    import plb_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], value[10:3], position[18:11], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // status[1:0], element[9:2], length[14:10], zero pad
    input  logic        m_tlast,   // last_of_run
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] element;
        logic [LEN_W-1:0]  length;
        logic              ends_run;
    } result_t;

    result_t           due_beats[$];
    logic [DATA_W-1:0] shadow_row [0:CAPACITY-1];
    int unsigned       shadow_len = 0;
    int                misses     = 0;

    task automatic post_status(input logic [1:0] code);
        due_beats.push_back({code, {DATA_W{1'b0}}, shadow_len[LEN_W-1:0], 1'b1});
    endtask

    task automatic model_insert(input int unsigned pos, input logic [DATA_W-1:0] val);
        int unsigned i;
        if (pos < 1 || pos > shadow_len + 1)
            post_status(ST_IGNORED);
        else if (shadow_len >= CAPACITY)
            post_status(ST_FULL);
        else
        begin
            for (i = shadow_len; i >= pos; i--)
                shadow_row[i] = shadow_row[i-1];
            shadow_row[pos-1] = val;
            shadow_len++;
            post_status(ST_DONE);
        end
    endtask

    task automatic model_delete(input int unsigned pos);
        int unsigned i;
        if (shadow_len == 0 || pos < 1 || pos > shadow_len)
            post_status(ST_IGNORED);
        else
        begin
            for (i = pos - 1; i + 1 < shadow_len; i++)
                shadow_row[i] = shadow_row[i+1];
            shadow_len--;
            post_status(ST_DONE);
        end
    endtask

    task automatic model_request(input logic [23:0] req);
        logic [2:0]        act;
        logic [DATA_W-1:0] val;
        int unsigned       pos;
        int unsigned       i;
        act = req[2:0];
        val = req[10:3];
        pos = 32'(req[18:11]);
        case (act)
            ACT_INS_FRONT: model_insert(1, val);
            ACT_INS_BACK:  model_insert(shadow_len + 1, val);
            ACT_DEL_FRONT: model_delete(1);
            ACT_DEL_BACK:  model_delete(shadow_len);
            ACT_INS_AT:    model_insert(pos, val);
            ACT_DEL_AT:    model_delete(pos);
            ACT_LIST:
                for (i = 0; i < shadow_len; i++)
                    due_beats.push_back({ST_LISTED, shadow_row[i], shadow_len[LEN_W-1:0],
                                         i + 1 == shadow_len});
            default:       post_status(ST_IGNORED);
        endcase
    endtask

    task automatic check_beat(input result_t got);
        result_t want;
        if (due_beats.size() == 0)
        begin
            misses++;
            if (misses <= 10)
                $display("%0t plb_checker: unexpected beat st=%0d el=%0d len=%0d last=%0b",
                         $realtime, got.status, got.element, got.length, got.ends_run);
        end
        else
        begin
            want = due_beats.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.length !== want.length || got.ends_run !== want.ends_run)
            begin
                misses++;
                if (misses <= 10)
                begin
                    $display("%0t plb_checker: exp st=%0d el=%0d len=%0d last=%0b",
                             $realtime, want.status, want.element, want.length,
                             want.ends_run);
                    $display("%0t plb_checker: got st=%0d el=%0d len=%0d last=%0b",
                             $realtime, got.status, got.element, got.length,
                             got.ends_run);
                end
            end
        end
    endtask

    // Results are registered and leave only after their request is accepted, so the result side is handled first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            due_beats.delete();
            pending    <= 0;
            fail_count <= misses;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_beat({m_tdata[1:0], m_tdata[9:2], m_tdata[14:10], m_tlast});
            if (s_tvalid && s_tready)
                model_request(s_tdata);
            pending    <= due_beats.size();
            fail_count <= misses;
        end
    end

endmodule

// File: dv/positional_list_buffer_test.sv
`timescale 1ns / 1ps
// Top of the positional list buffer test: clock, reset, request stimulus, result-side stalls
// and the verdict. Depends on plb_pkg, positional_list_buffer and plb_checker.
module positional_list_buffer_test
    import plb_pkg::*;
();

    localparam int         CAP        = 16;
    localparam logic [2:0] ACT_UNUSED = 3'd7;   // undefined request code, must be ignored
    localparam int         RUN_ITEMS  = 200;
    localparam int         STALL_MAX  = 11;
    localparam int         IDLE_LIMIT = 400;    // cycles with no beat on either side
    localparam int         DRAIN_WAIT = 20;

    // random-phase flavors: GROW pushes toward full, SHRINK toward empty
    typedef enum logic [1:0] {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // action[2:0], value[10:3], position[18:11], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // status[1:0], element[9:2], length[14:10], zero pad
    logic        m_tlast;        // last_of_run

    int          fail_count;
    int          pending;
    int unsigned fill_guess = 0; // length as the stimulus sees it, only used to aim positions
    int unsigned rx_gap;
    int unsigned idle_cycles = 0;
    logic        rush = 1'b0;    // when set neither side idles

    always #10 clk = ~clk;

    positional_list_buffer #(.CAPACITY(CAP)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    plb_checker #(.CAPACITY(CAP)) scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Rough length after a request; steers positions toward the edges of the valid range.
    function automatic int unsigned len_next(input logic [2:0] act, input logic [7:0] pos,
                                             input int unsigned n);
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK: return (n < CAP) ? n + 1 : n;
            ACT_INS_AT:    return (pos >= 1 && pos <= n + 1 && n < CAP) ? n + 1 : n;
            ACT_DEL_FRONT, ACT_DEL_BACK: return (n > 0) ? n - 1 : n;
            ACT_DEL_AT:    return (pos >= 1 && pos <= n) ? n - 1 : n;
            default:       return n;
        endcase
    endfunction

    // Mostly in range, with zero, one past the end, the end itself and wild values mixed in.
    function automatic logic [7:0] pick_pos(input int unsigned limit);
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'(limit + 1);
            2:       return 8'($urandom_range(0, 255));
            3:       return 8'(limit);
            default: return 8'($urandom_range(1, (limit == 0) ? 1 : limit));
        endcase
    endfunction

    // One request beat: optional idle gap, then hold valid until accepted.
    // valid stays high across back-to-back beats so it never gets two writes in one step.
    task automatic send_request(input logic [2:0] act, input logic [7:0] val,
                                input logic [7:0] pos);
        int unsigned gap;
        gap = rush ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pos, val, act};
        do @(posedge clk); while (!s_tready);
        fill_guess = len_next(act, pos, fill_guess);
    endtask

    task automatic random_request(input phase_t ph);
        int unsigned roll;
        int unsigned ins_w;
        int unsigned del_w;
        logic [2:0]  act;
        logic [7:0]  pos;
        case (ph)
            PH_GROW:   begin ins_w = 65; del_w = 20; end
            PH_SHRINK: begin ins_w = 20; del_w = 65; end
            default:   begin ins_w = 43; del_w = 42; end
        endcase
        roll = $urandom_range(0, 99);
        pos  = 8'($urandom_range(0, 255));   // noise in the field when the request ignores it
        if (roll < ins_w)
        begin
            case ($urandom_range(0, 2))
                0:       act = ACT_INS_FRONT;
                1:       act = ACT_INS_BACK;
                default: begin act = ACT_INS_AT; pos = pick_pos(fill_guess + 1); end
            endcase
        end
        else if (roll < ins_w + del_w)
        begin
            case ($urandom_range(0, 2))
                0:       act = ACT_DEL_FRONT;
                1:       act = ACT_DEL_BACK;
                default: begin act = ACT_DEL_AT; pos = pick_pos(fill_guess); end
            endcase
        end
        else if (roll < 98)
            act = ACT_LIST;
        else
            act = ACT_UNUSED;
        send_request(act, 8'($urandom_range(0, 255)), pos);
    endtask

    // Result side: a fresh stall per beat; ready is only lowered when a stall is drawn,
    // so it is never dropped and raised within one step.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rx_gap = rush ? 0 : $urandom_range(0, STALL_MAX);
            if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Watchdog: a correct run never goes this long without a beat on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("positional_list_buffer: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int     sent;
        int     span;
        int     k;
        phase_t ph;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases, bad positions, full value range, unknown code,
        // removing the sole element, listing empty / single / several.
        send_request(ACT_LIST,      8'h00, 8'h00);   // empty list: no beats
        send_request(ACT_DEL_FRONT, 8'h00, 8'h00);   // delete on empty
        send_request(ACT_DEL_BACK,  8'h00, 8'h00);
        send_request(ACT_DEL_AT,    8'h00, 8'd1);
        send_request(ACT_INS_AT,    8'h11, 8'd0);    // position zero
        send_request(ACT_INS_AT,    8'h22, 8'd2);    // past length+1
        send_request(ACT_INS_FRONT, 8'h00, 8'h00);
        send_request(ACT_INS_BACK,  8'hFF, 8'hFF);
        send_request(ACT_INS_AT,    8'hA5, 8'd2);    // middle
        send_request(ACT_INS_AT,    8'h5A, 8'd4);    // exactly length+1
        send_request(ACT_INS_AT,    8'h3C, 8'hFF);   // far out of range
        send_request(ACT_LIST,      8'h00, 8'h00);
        send_request(ACT_DEL_AT,    8'h00, 8'd0);
        send_request(ACT_DEL_AT,    8'h00, 8'd5);    // one past the end
        send_request(ACT_DEL_AT,    8'h00, 8'd4);    // the back by position
        send_request(ACT_DEL_AT,    8'h00, 8'd2);
        send_request(ACT_UNUSED,    8'hFF, 8'hFF);
        send_request(ACT_DEL_FRONT, 8'h00, 8'h00);
        send_request(ACT_DEL_BACK,  8'h00, 8'h00);   // removes the only element
        send_request(ACT_LIST,      8'h00, 8'h00);
        send_request(ACT_INS_AT,    8'h80, 8'd1);    // insert into empty by position
        send_request(ACT_LIST,      8'h00, 8'h00);

        // Random: phases that fill up, drain and churn, some of them without idling.
        sent = 0;
        k    = 0;
        while (sent < RUN_ITEMS)
        begin
            ph    = phase_t'(k % 3);
            span  = $urandom_range(20, 35);
            rush <= ($urandom_range(0, 3) == 0);
            repeat (span)
            begin
                random_request(ph);
                sent++;
            end
            k++;
        end
        s_tvalid <= 1'b0;
        rush     <= 1'b0;

        // let the scoreboard take in the final request before judging what is due
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("positional_list_buffer: match");
        else
            $display("positional_list_buffer: mismatch");
        $finish;
    end

endmodule

// File: positional_list_buffer.f
sv/plb_pkg.sv
sv/plb_cell.sv
sv/positional_list_buffer.sv
dv/plb_checker.sv
dv/positional_list_buffer_test.sv
